// ===== hdl/bda_pkg.sv =====
// Shared types and constants for the difficulty adjustment block.
// Holds the transfer payload structs, the register file layout and the rule constants.
// No dependencies.
`default_nettype none

package bda_pkg;

  // Default datapath width of a difficulty value.
  localparam int unsigned DIFFICULTY_BITS_DEF = 64;

  // Register port layout: seven 64-bit registers at 8-byte spacing.
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_ADDR_W   = 6;
  localparam int unsigned REG_ADDR_LSB = 3;

  typedef enum logic [2:0] {
    REG_HOMESTEAD      = 3'd0,
    REG_BYZANTIUM      = 3'd1,
    REG_CONSTANTINOPLE = 3'd2,
    REG_MUIR_GLACIER   = 3'd3,
    REG_LONDON         = 3'd4,
    REG_ARROW_GLACIER  = 3'd5,
    REG_MIN_DIFFICULTY = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] homestead_fork_block;
    logic [63:0] byzantium_fork_block;
    logic [63:0] constantinople_fork_block;
    logic [63:0] muir_glacier_fork_block;
    logic [63:0] london_fork_block;
    logic [63:0] arrow_glacier_fork_block;
    logic [63:0] minimum_difficulty;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    homestead_fork_block:      64'd1150000,
    byzantium_fork_block:      64'd4370000,
    constantinople_fork_block: 64'd7280000,
    muir_glacier_fork_block:   64'd9200000,
    london_fork_block:         64'd12965000,
    arrow_glacier_fork_block:  64'd13773000,
    minimum_difficulty:        64'd131072
  };

  typedef struct packed {
    logic [63:0] new_block_number;
    logic [63:0] new_block_time;
    logic [63:0] parent_block_difficulty;
    logic [63:0] parent_block_time;
    logic        parent_had_uncles;
  } in_t;

  typedef struct packed {
    logic [63:0] new_difficulty;
    logic        difficulty_saturated;
  } out_t;

  // Adjustment rule constants.
  localparam int unsigned STEP_SHIFT        = 11;
  localparam int unsigned HOM_BASE_MULT     = 99;
  localparam int unsigned HOM_TOP           = 100;
  localparam int unsigned BYZ_TOP_UNCLE     = 101;
  localparam int unsigned BYZ_DIV           = 9;
  localparam int unsigned HOM_DIV           = 10;
  localparam int unsigned FRONTIER_FAST_DT  = 13;
  localparam int unsigned KW                = 7;

  // Small quotients dt / 9 and dt / 10 for dt below 1024: (dt * RECIP) >> RECIP_SHIFT.
  localparam int unsigned DT_W              = 10;
  localparam int unsigned RECIP_W           = 10;
  localparam int unsigned RECIP_SHIFT       = 13;
  localparam logic [RECIP_W-1:0] RECIP_DIV9  = 10'd911;
  localparam logic [RECIP_W-1:0] RECIP_DIV10 = 10'd820;

  // Bomb term: period count n = adj / 100000 = (adj * BOMB_RECIP) >> BOMB_RECIP_SHIFT,
  // exact for adj below 2^23.
  localparam int unsigned ERA_LEN           = 100000;
  localparam int unsigned ADJ_W             = 23;
  localparam int unsigned BOMB_RECIP_W      = 24;
  localparam int unsigned BOMB_RECIP_SHIFT  = 40;
  localparam logic [BOMB_RECIP_W-1:0] BOMB_RECIP = 24'd10995117;
  localparam int unsigned N_W               = 7;
  localparam int unsigned BOMB_N_MIN        = 2;

  localparam int unsigned DELAY_BYZANTIUM   = 3000000;
  localparam int unsigned DELAY_CONST       = 5000000;
  localparam int unsigned DELAY_MUIR        = 9000000;
  localparam int unsigned DELAY_LONDON      = 9700000;
  localparam int unsigned DELAY_ARROW       = 10700000;

endpackage

`default_nettype wire

// ===== hdl/block_difficulty_adjust.sv =====
// Each result passes through the registered stages A to F before it is valid at the output.
// Throughput: one transfer per cycle; ready drops only when all six stages hold items
// and the result at the output is not taken; the stall ripples back through the stage enables.
// Reset: asynchronous, active low; empties the pipeline and loads the register defaults.
// No memories, so there is no clearing pass after reset.
// Top level of the difficulty block; instantiates bda_regs and bda_pipe, uses bda_pkg.
`default_nettype none

module block_difficulty_adjust import bda_pkg::*; #(
  parameter int unsigned DifficultyBits = DIFFICULTY_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Configuration port. A write lands at the edge where psel, penable, pwrite and
  // pready are high; register i sits at byte address 8*i.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,

  // Input channel: one block header per transfer.
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  in_t                        in_data_i,

  // Output channel: one difficulty per transfer.
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o
);

  // The register values feed stage A (fork thresholds) and stage F (minimum clamp).
  // Writes are expected only while no transfer is in flight, so a header always
  // sees one consistent set of registers.
  cfg_t cfg;

  bda_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The datapath is cut into six stages: fork decode and time difference, bomb delay
  // and base term, small quotient and bomb period count, step multiple and bomb
  // power of two, the wide sum, and the final saturate-and-clamp output register.
  // Each stage has its own valid bit and loads whenever it is empty or its item moves
  // on, so bubbles close up and a stalled output never drops or duplicates an item.
  bda_pipe #(
    .DifficultyBits (DifficultyBits)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/bda_regs.sv =====
// Register file behind the APB-style configuration port.
// Holds the fork block numbers and the minimum difficulty; uses bda_pkg.
`default_nettype none

module bda_regs import bda_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:REG_ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HOMESTEAD:      cfg_d.homestead_fork_block      = pwdata;
        REG_BYZANTIUM:      cfg_d.byzantium_fork_block      = pwdata;
        REG_CONSTANTINOPLE: cfg_d.constantinople_fork_block = pwdata;
        REG_MUIR_GLACIER:   cfg_d.muir_glacier_fork_block   = pwdata;
        REG_LONDON:         cfg_d.london_fork_block         = pwdata;
        REG_ARROW_GLACIER:  cfg_d.arrow_glacier_fork_block  = pwdata;
        REG_MIN_DIFFICULTY: cfg_d.minimum_difficulty        = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOMESTEAD:      prdata = cfg_q.homestead_fork_block;
      REG_BYZANTIUM:      prdata = cfg_q.byzantium_fork_block;
      REG_CONSTANTINOPLE: prdata = cfg_q.constantinople_fork_block;
      REG_MUIR_GLACIER:   prdata = cfg_q.muir_glacier_fork_block;
      REG_LONDON:         prdata = cfg_q.london_fork_block;
      REG_ARROW_GLACIER:  prdata = cfg_q.arrow_glacier_fork_block;
      REG_MIN_DIFFICULTY: prdata = cfg_q.minimum_difficulty;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bda_pipe.sv =====
// Six-stage difficulty datapath with per-stage valid bits and stall control.
// Uses bda_pkg for payload types and rule constants.
`default_nettype none

module bda_pipe import bda_pkg::*; #(
  parameter int unsigned DifficultyBits = DIFFICULTY_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  in_t       in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned DB    = DifficultyBits;
  localparam int unsigned SW    = DB - STEP_SHIFT;
  localparam int unsigned AW    = SW + KW;
  localparam int unsigned SUMW  = DB + 1;
  localparam int unsigned ZPW   = DT_W + RECIP_W;
  localparam int unsigned NPW   = ADJ_W + BOMB_RECIP_W;
  localparam int unsigned NS    = 6;
  localparam logic [DB-1:0] DIFF_MAX  = {DB{1'b1}};
  localparam logic [63:0]   BOMB_SPAN = 64'((DB + BOMB_N_MIN) * ERA_LEN);

  typedef struct packed {
    logic [63:0]   num;
    logic [63:0]   dt;
    logic [DB-1:0] par;
    logic          unc;
    logic          hom;
    logic          byz;
    logic          con;
    logic          lon;
    logic          muir;
    logic          arrow;
  } sa_t;

  typedef struct packed {
    logic [DB-1:0]    par;
    logic [SW-1:0]    step;
    logic [DB-1:0]    base;
    logic             hom;
    logic             byz;
    logic             dt_small;
    logic             fast;
    logic [KW-1:0]    top;
    logic [DT_W-1:0]  dt10;
    logic             bomb_sat;
    logic [ADJ_W-1:0] adj;
  } sb_t;

  typedef struct packed {
    logic [SW-1:0]   step;
    logic [DB-1:0]   base;
    logic [SUMW-1:0] front;
    logic            hom;
    logic [KW-1:0]   k;
    logic            bomb_sat;
    logic [N_W-1:0]  n;
  } sc_t;

  typedef struct packed {
    logic [DB-1:0]   base;
    logic [AW-1:0]   add;
    logic [SUMW-1:0] front;
    logic            hom;
    logic [DB-1:0]   bomb;
    logic            bomb_sat;
  } sd_t;

  typedef struct packed {
    logic [SUMW-1:0] sum;
    logic            bomb_sat;
  } se_t;

  function automatic logic fork_reached(logic [63:0] fork_blk, logic [63:0] num);
    return (fork_blk != '1) && (num >= fork_blk);
  endfunction

  logic [NS-1:0] v_q, v_d, en;
  sa_t  sa_q, sa_d;
  sb_t  sb_q, sb_d;
  sc_t  sc_q, sc_d;
  sd_t  sd_q, sd_d;
  se_t  se_q, se_d;
  out_t so_q, so_d;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        v_d[i] = v_q[i-1];
      end else begin
        v_d[i] = v_q[i];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = so_q;

  // Stage A: fork decode, time difference, parent difficulty.
  always_comb begin
    sa_d.num   = in_data_i.new_block_number;
    sa_d.dt    = in_data_i.new_block_time - in_data_i.parent_block_time;
    sa_d.par   = in_data_i.parent_block_difficulty[DB-1:0];
    sa_d.unc   = in_data_i.parent_had_uncles;
    sa_d.lon   = fork_reached(cfg_i.london_fork_block, in_data_i.new_block_number);
    sa_d.con   = sa_d.lon ||
                 fork_reached(cfg_i.constantinople_fork_block, in_data_i.new_block_number);
    sa_d.byz   = sa_d.con ||
                 fork_reached(cfg_i.byzantium_fork_block, in_data_i.new_block_number);
    sa_d.hom   = sa_d.byz ||
                 fork_reached(cfg_i.homestead_fork_block, in_data_i.new_block_number);
    sa_d.muir  = fork_reached(cfg_i.muir_glacier_fork_block, in_data_i.new_block_number);
    sa_d.arrow = fork_reached(cfg_i.arrow_glacier_fork_block, in_data_i.new_block_number);
  end

  // Stage B: bomb delay, base term, time-difference classification.
  logic [63:0] delay_b, thr_b, diff_b;
  logic [AW-1:0] base_mul_b;
  logic [DT_W-1:0] limit_b;

  always_comb begin
    priority if (sa_q.arrow) begin
      delay_b = 64'(DELAY_ARROW);
      thr_b   = 64'(DELAY_ARROW) + BOMB_SPAN;
    end else if (sa_q.lon) begin
      delay_b = 64'(DELAY_LONDON);
      thr_b   = 64'(DELAY_LONDON) + BOMB_SPAN;
    end else if (sa_q.muir) begin
      delay_b = 64'(DELAY_MUIR);
      thr_b   = 64'(DELAY_MUIR) + BOMB_SPAN;
    end else if (sa_q.con) begin
      delay_b = 64'(DELAY_CONST);
      thr_b   = 64'(DELAY_CONST) + BOMB_SPAN;
    end else if (sa_q.byz) begin
      delay_b = 64'(DELAY_BYZANTIUM);
      thr_b   = 64'(DELAY_BYZANTIUM) + BOMB_SPAN;
    end else begin
      delay_b = '0;
      thr_b   = BOMB_SPAN;
    end

    diff_b       = sa_q.num - delay_b;
    sb_d.par     = sa_q.par;
    sb_d.step    = sa_q.par[DB-1:STEP_SHIFT];
    base_mul_b   = AW'(sb_d.step) * AW'(HOM_BASE_MULT);
    sb_d.base    = sa_q.par - DB'(base_mul_b);
    sb_d.hom     = sa_q.hom;
    sb_d.byz     = sa_q.byz;
    sb_d.top     = (sa_q.byz && sa_q.unc) ? KW'(BYZ_TOP_UNCLE) : KW'(HOM_TOP);

    // The quotient stays below the top value exactly when dt < divisor * top.
    if (sa_q.byz) begin
      limit_b = sa_q.unc ? DT_W'(BYZ_DIV * BYZ_TOP_UNCLE) : DT_W'(BYZ_DIV * HOM_TOP);
    end else begin
      limit_b = DT_W'(HOM_DIV * HOM_TOP);
    end
    sb_d.dt_small = sa_q.dt < 64'(limit_b);
    sb_d.dt10     = sa_q.dt[DT_W-1:0];
    sb_d.fast     = sa_q.dt < 64'(FRONTIER_FAST_DT);

    sb_d.bomb_sat = sa_q.num >= thr_b;
    sb_d.adj      = (sa_q.num > delay_b) ? diff_b[ADJ_W-1:0] : '0;
  end

  // Stage C: small quotient and step count, frontier value, bomb period count.
  logic [ZPW-1:0] zprod_c;
  logic [KW-1:0]  z_c;
  logic [NPW-1:0] nprod_c;

  always_comb begin
    zprod_c    = ZPW'(sb_q.dt10) * ZPW'(sb_q.byz ? RECIP_DIV9 : RECIP_DIV10);
    z_c        = zprod_c[RECIP_SHIFT +: KW];
    sc_d.k     = sb_q.dt_small ? (sb_q.top - z_c) : '0;
    sc_d.step  = sb_q.step;
    sc_d.base  = sb_q.base;
    sc_d.hom   = sb_q.hom;
    sc_d.front = sb_q.fast ? (SUMW'(sb_q.par) + SUMW'(sb_q.step))
                           : (SUMW'(sb_q.par) - SUMW'(sb_q.step));
    nprod_c       = NPW'(sb_q.adj) * NPW'(BOMB_RECIP);
    sc_d.n        = nprod_c[BOMB_RECIP_SHIFT +: N_W];
    sc_d.bomb_sat = sb_q.bomb_sat;
  end

  // Stage D: step multiple and bomb power of two.
  always_comb begin
    sd_d.base     = sc_q.base;
    sd_d.add      = AW'(sc_q.step) * AW'(sc_q.k);
    sd_d.front    = sc_q.front;
    sd_d.hom      = sc_q.hom;
    sd_d.bomb_sat = sc_q.bomb_sat;
    if (sc_q.n >= N_W'(BOMB_N_MIN)) begin
      sd_d.bomb = DB'(1) << (sc_q.n - N_W'(BOMB_N_MIN));
    end else begin
      sd_d.bomb = '0;
    end
  end

  // Stage E: full-width sum.
  always_comb begin
    se_d.sum      = (sd_q.hom ? (SUMW'(sd_q.base) + SUMW'(sd_q.add)) : sd_q.front)
                    + SUMW'(sd_q.bomb);
    se_d.bomb_sat = sd_q.bomb_sat;
  end

  // Stage F: saturate and clamp to the minimum.
  logic          sat_f;
  logic [DB-1:0] val_f, mind_f, res_f;

  always_comb begin
    sat_f  = se_q.bomb_sat || se_q.sum[DB];
    val_f  = sat_f ? DIFF_MAX : se_q.sum[DB-1:0];
    mind_f = cfg_i.minimum_difficulty[DB-1:0];
    res_f  = (val_f < mind_f) ? mind_f : val_f;
    so_d.new_difficulty       = 64'(res_f);
    so_d.difficulty_saturated = sat_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) sa_q <= sa_d;
    if (en[1]) sb_q <= sb_d;
    if (en[2]) sc_q <= sc_d;
    if (en[3]) sd_q <= sd_d;
    if (en[4]) se_q <= se_d;
    if (en[5]) so_q <= so_d;
  end

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled while the pipeline has an empty stage");

  a_step_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (sc_q.k <= KW'(BYZ_TOP_UNCLE)))
    else $error("step multiple exceeds the largest top value");

  a_bomb_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> $onehot0(sd_q.bomb))
    else $error("bomb term has more than one bit set");

  a_saturated_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.difficulty_saturated) |->
      (out_data_o.new_difficulty == 64'(DIFF_MAX)))
    else $error("saturated result is not the maximum difficulty");

endmodule

`default_nettype wire
